// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers used by the translator rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/tpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tpt_pkg
// shared types and constants of the tlb and page table translator
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int VA_W    = 16;
  localparam int PA_W    = 15;
  localparam int STAMP_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TLB,
    ST_PT,
    ST_VICT,
    ST_SLOT,
    ST_FILL,
    ST_TOUCH,
    ST_DONE
  } state_t;

  // control of the shared victim search unit
  typedef struct packed {
    logic clr;
    logic step;
    logic first;
    logic empty;
  } trk_ctl_t;

  typedef struct packed {
    logic fill;
    logic touch;
  } frm_wr_t;

  typedef struct packed {
    logic fill;
    logic clr;
  } tlb_wr_t;

endpackage

// ----- design/tpt_victim_track.sv -----
// ----------------------------------------------------------------------------
// tpt_victim_track
// running first-free and minimum-stamp search, one entry per step
// ----------------------------------------------------------------------------
module tpt_victim_track #(
  parameter int IW = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tpt_pkg::trk_ctl_t       ctl,
  input  logic [IW-1:0]           idx,
  input  logic [tpt_pkg::STAMP_W-1:0] stamp,
  output logic                    found_free,
  output logic [IW-1:0]           pick
);
  import tpt_pkg::*;

  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      best_idx;
  logic [STAMP_W-1:0] best_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      found_free <= 1'b0;
    end else if (ctl.clr) begin
      found_free <= 1'b0;
    end else if (ctl.step && !found_free && ctl.empty) begin
      found_free <= 1'b1;
    end
  end

  // strict less-than keeps the lowest index on equal stamps
  always_ff @(posedge clk) begin
    if (ctl.step && !found_free) begin
      if (ctl.empty) begin
        free_idx <= idx;
      end
      if (ctl.first || (stamp < best_stamp)) begin
        best_idx   <= idx;
        best_stamp <= stamp;
      end
    end
  end

  assign pick = found_free ? free_idx : best_idx;

endmodule

// ----- design/tpt_frame_store.sv -----
// ----------------------------------------------------------------------------
// tpt_frame_store
// page table frames: page number and stamp memories plus valid bits
// ----------------------------------------------------------------------------
module tpt_frame_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int PW    = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [AW-1:0]               rd_addr,
  input  tpt_pkg::frm_wr_t            wr,
  input  logic [AW-1:0]               wr_addr,
  input  logic [PW-1:0]               wr_page,
  input  logic [tpt_pkg::STAMP_W-1:0] wr_stamp,
  output logic                        rd_valid,
  output logic [PW-1:0]               rd_page,
  output logic [tpt_pkg::STAMP_W-1:0] rd_load,
  output logic [tpt_pkg::STAMP_W-1:0] rd_use
);
  import tpt_pkg::*;

  logic [PW-1:0]      page_mem [DEPTH];
  logic [STAMP_W-1:0] load_mem [DEPTH];
  logic [STAMP_W-1:0] use_mem  [DEPTH];
  logic [DEPTH-1:0]   valid;

  always_ff @(posedge clk) begin
    if (wr.fill) begin
      page_mem[wr_addr] <= wr_page;
      load_mem[wr_addr] <= wr_stamp;
    end
    if (wr.fill || wr.touch) begin
      use_mem[wr_addr] <= wr_stamp;
    end
    rd_page <= page_mem[rd_addr];
    rd_load <= load_mem[rd_addr];
    rd_use  <= use_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.fill) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[rd_addr];
  end

endmodule

// ----- design/tpt_tlb_store.sv -----
// ----------------------------------------------------------------------------
// tpt_tlb_store
// tlb entries: page, frame and insert stamp memory plus valid bits
// ----------------------------------------------------------------------------
module tpt_tlb_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int PW    = 8,
  parameter int FW    = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [AW-1:0]               rd_addr,
  input  tpt_pkg::tlb_wr_t            wr,
  input  logic [AW-1:0]               wr_addr,
  input  logic [PW-1:0]               wr_page,
  input  logic [FW-1:0]               wr_frame,
  input  logic [tpt_pkg::STAMP_W-1:0] wr_stamp,
  output logic                        rd_valid,
  output logic [PW-1:0]               rd_page,
  output logic [FW-1:0]               rd_frame,
  output logic [tpt_pkg::STAMP_W-1:0] rd_stamp
);
  import tpt_pkg::*;

  logic [PW-1:0]      page_mem  [DEPTH];
  logic [FW-1:0]      frame_mem [DEPTH];
  logic [STAMP_W-1:0] stamp_mem [DEPTH];
  logic [DEPTH-1:0]   valid;

  always_ff @(posedge clk) begin
    if (wr.fill) begin
      page_mem[wr_addr]  <= wr_page;
      frame_mem[wr_addr] <= wr_frame;
      stamp_mem[wr_addr] <= wr_stamp;
    end
    rd_page  <= page_mem[rd_addr];
    rd_frame <= frame_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.fill) begin
      valid[wr_addr] <= 1'b1;
    end else if (wr.clr) begin
      valid[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[rd_addr];
  end

endmodule

// ----- design/tlb_page_table_translator.sv -----
// throughput: one item at a time; a new address is accepted only once the last
//   result has been loaded to the output, the block being held by the
//   entry-per-cycle scans through the single read port of each memory
// reset: synchronous; valid bits, counter and mode clear at once, no clearing pass
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// virtual to physical translation with a tlb and a fifo or lru page table
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int FRAME_COUNT = 128,
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_BYTES  = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     replacement_mode,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [tpt_pkg::VA_W-1:0] virtual_address,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [tpt_pkg::PA_W-1:0] physical_address,
  output logic                     tlb_hit,
  output logic                     page_fault
);
  import tpt_pkg::*;

  `include "assert_macros.svh"

  // page size is a power of two: page and offset are bit fields
  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int PW    = VA_W - OFF_W;
  localparam int FW    = $clog2(FRAME_COUNT);
  localparam int TW    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int IW    = (FW > TW) ? FW : TW;
  localparam int SW    = IW + 1;

  state_t state, state_next;

  logic [SW-1:0]      idx;
  logic               live;
  logic [IW-1:0]      chk_idx;
  logic               issue;
  logic [PW-1:0]      page_reg;
  logic [OFF_W-1:0]   offset_reg;
  logic [FW-1:0]      frame_reg;
  logic               hit_reg;
  logic               fault_reg;
  logic               evict;
  logic               mode;
  logic [STAMP_W-1:0] access_counter;
  logic               out_load;

  logic               f_rd_valid;
  logic [PW-1:0]      f_rd_page;
  logic [STAMP_W-1:0] f_rd_load;
  logic [STAMP_W-1:0] f_rd_use;
  frm_wr_t            frm_wr;

  logic               t_rd_valid;
  logic [PW-1:0]      t_rd_page;
  logic [FW-1:0]      t_rd_frame;
  logic [STAMP_W-1:0] t_rd_stamp;
  tlb_wr_t            tlb_wr;
  logic [TW-1:0]      tlb_wr_addr;

  trk_ctl_t           trk;
  logic [STAMP_W-1:0] trk_stamp;
  logic               found_free;
  logic [IW-1:0]      pick;

  logic               tlb_match;
  logic               frm_match;
  logic               inv_hit;
  logic               last_tlb;
  logic               last_frm;
  logic [PA_W+FW+OFF_W-1:0] pa_ext;

  tpt_frame_store #(
    .DEPTH (FRAME_COUNT),
    .AW    (FW),
    .PW    (PW)
  ) u_frames (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (idx[FW-1:0]),
    .wr       (frm_wr),
    .wr_addr  (frame_reg),
    .wr_page  (page_reg),
    .wr_stamp (access_counter),
    .rd_valid (f_rd_valid),
    .rd_page  (f_rd_page),
    .rd_load  (f_rd_load),
    .rd_use   (f_rd_use)
  );

  tpt_tlb_store #(
    .DEPTH (TLB_ENTRIES),
    .AW    (TW),
    .PW    (PW),
    .FW    (FW)
  ) u_tlb (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (idx[TW-1:0]),
    .wr       (tlb_wr),
    .wr_addr  (tlb_wr_addr),
    .wr_page  (page_reg),
    .wr_frame (frame_reg),
    .wr_stamp (access_counter),
    .rd_valid (t_rd_valid),
    .rd_page  (t_rd_page),
    .rd_frame (t_rd_frame),
    .rd_stamp (t_rd_stamp)
  );

  tpt_victim_track #(
    .IW (IW)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .ctl        (trk),
    .idx        (chk_idx),
    .stamp      (trk_stamp),
    .found_free (found_free),
    .pick       (pick)
  );

  // compare stage, one entry read back per cycle
  assign tlb_match = live && t_rd_valid && (t_rd_page == page_reg);
  assign frm_match = live && f_rd_valid && (f_rd_page == page_reg);
  assign inv_hit   = live && evict && t_rd_valid && (t_rd_frame == frame_reg);
  assign last_tlb  = live && (chk_idx == IW'(TLB_ENTRIES - 1));
  assign last_frm  = live && (chk_idx == IW'(FRAME_COUNT - 1));
  assign trk_stamp = (state == ST_PT) ? (mode ? f_rd_use : f_rd_load) : t_rd_stamp;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_TLB;
        end
      end
      ST_TLB: begin
        if (tlb_match) begin
          state_next = ST_TOUCH;
        end else if (last_tlb) begin
          state_next = ST_PT;
        end
      end
      ST_PT: begin
        if (frm_match) begin
          state_next = ST_TOUCH;
        end else if (last_frm) begin
          state_next = ST_VICT;
        end
      end
      ST_VICT: begin
        state_next = ST_SLOT;
      end
      ST_SLOT: begin
        if (last_tlb) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL, ST_TOUCH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    frm_wr      = '0;
    tlb_wr      = '0;
    tlb_wr_addr = chk_idx[TW-1:0];
    trk.clr     = 1'b0;
    trk.step    = 1'b0;
    trk.first   = (chk_idx == '0);
    trk.empty   = !f_rd_valid;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        trk.clr  = 1'b1;
      end
      ST_TLB: begin
        issue = (idx < SW'(TLB_ENTRIES));
      end
      ST_PT: begin
        issue    = (idx < SW'(FRAME_COUNT));
        trk.step = live;
      end
      ST_VICT: begin
        trk.clr = 1'b1;
      end
      ST_SLOT: begin
        // an entry dropped for the evicted frame counts as free
        issue      = (idx < SW'(TLB_ENTRIES));
        trk.step   = live;
        trk.empty  = !t_rd_valid || inv_hit;
        tlb_wr.clr = inv_hit;
      end
      ST_FILL: begin
        frm_wr.fill = 1'b1;
        tlb_wr.fill = 1'b1;
        tlb_wr_addr = pick[TW-1:0];
      end
      ST_TOUCH: begin
        frm_wr.touch = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      idx            <= '0;
      live           <= 1'b0;
      out_valid      <= 1'b0;
      access_counter <= '0;
      mode           <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + SW'(1);
      end
      live <= issue && (state_next == state);
      if (cfg_valid) begin
        mode <= replacement_mode;
      end
      if (out_load) begin
        out_valid      <= 1'b1;
        access_counter <= access_counter + STAMP_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pa_ext = {{PA_W{1'b0}}, frame_reg, offset_reg};

  always_ff @(posedge clk) begin
    chk_idx <= idx[IW-1:0];
    if (in_valid && in_ready) begin
      page_reg   <= virtual_address[VA_W-1:OFF_W];
      offset_reg <= virtual_address[OFF_W-1:0];
      hit_reg    <= 1'b0;
      fault_reg  <= 1'b0;
      evict      <= 1'b0;
    end
    if (state == ST_TLB && tlb_match) begin
      frame_reg <= t_rd_frame;
      hit_reg   <= 1'b1;
    end
    if (state == ST_PT && frm_match) begin
      frame_reg <= chk_idx[FW-1:0];
    end
    if (state == ST_VICT) begin
      frame_reg <= pick[FW-1:0];
      evict     <= !found_free;
      fault_reg <= 1'b1;
    end
    if (out_load) begin
      physical_address <= pa_ext[PA_W-1:0];
      tlb_hit          <= hit_reg;
      page_fault       <= fault_reg;
    end
  end

  `ASSERT_NEXT(a_accept_scans_tlb, clk, rst, in_valid && in_ready, state == ST_TLB)
  `ASSERT_IMPLY(a_touch_not_fault, clk, rst, state == ST_TOUCH, !fault_reg)
  `ASSERT_IMPLY(a_fill_not_hit, clk, rst, state == ST_FILL, fault_reg && !hit_reg)
  `ASSERT_IMPLY(a_hit_fault_excl, clk, rst, out_valid, !(tlb_hit && page_fault))

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for tlb_page_table_translator
// checks each translation against a behavioral copy of the tlb and the frame
// table, with a directed table first and then locality-shaped random traffic
// under fifo and lru replacement, random idling on both sides
// ----------------------------------------------------------------------------
module testbench;
  import tpt_pkg::*;

  localparam int FRAMES      = 128;
  localparam int TLB_SLOTS   = 16;
  localparam int LONG_HOLD   = 800;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 207;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [VA_W-1:0] va;
    logic [PA_W-1:0] pa;
    logic            hit;
    logic            fault;
  } translation_t;

  typedef struct packed {
    logic         typed;
    translation_t value;
  } note_t;

  typedef struct packed {
    logic [VA_W-1:0] va;
    logic            typed;
    logic [PA_W-1:0] pa;
    logic            hit;
    logic            fault;
  } stim_row_t;

  // rows with typed=1 carry a result that is plain from the state at that point
  localparam stim_row_t DIRECTED [23] = '{
    '{16'h0000, 1'b1, 15'h0000, 1'b0, 1'b1},  // first access after reset
    '{16'hFFFF, 1'b1, 15'h01FF, 1'b0, 1'b1},  // top page, top offset
    '{16'h00FF, 1'b1, 15'h00FF, 1'b1, 1'b0},
    '{16'hFF00, 1'b1, 15'h0100, 1'b1, 1'b0},
    '{16'hAA55, 1'b1, 15'h0255, 1'b0, 1'b1},
    '{16'h55AA, 1'b1, 15'h03AA, 1'b0, 1'b1},
    '{16'h0180, 1'b0, 15'h0000, 1'b0, 1'b0},  // fill the rest of the tlb
    '{16'h0201, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h037F, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h04FE, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h0510, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h0620, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h0740, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h0808, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h0904, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h0A02, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h0B01, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h0CF0, 1'b0, 15'h0000, 1'b0, 1'b0},
    '{16'h1300, 1'b1, 15'h1000, 1'b0, 1'b1},  // full tlb, oldest entry replaced
    '{16'h0042, 1'b1, 15'h0042, 1'b0, 1'b0},  // frame table hit, tlb untouched
    '{16'h00C3, 1'b1, 15'h00C3, 1'b0, 1'b0},
    '{16'hFF7E, 1'b1, 15'h017E, 1'b1, 1'b0},
    '{16'h1301, 1'b1, 15'h1001, 1'b1, 1'b0}
  };

  logic            clk;
  logic            rst = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic            replacement_mode = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [VA_W-1:0] virtual_address = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [PA_W-1:0] physical_address;
  logic            tlb_hit;
  logic            page_fault;

  // behavioral copy of the translator state
  logic [7:0]  frm_page  [FRAMES];
  bit          frm_valid [FRAMES];
  bit   [31:0] frm_load  [FRAMES];
  bit   [31:0] frm_used  [FRAMES];
  logic [7:0]  slot_page [TLB_SLOTS];
  logic [6:0]  tlb_frame [TLB_SLOTS];
  bit          tlb_valid [TLB_SLOTS];
  bit   [31:0] tlb_born  [TLB_SLOTS];
  bit   [31:0] stamp_clock;
  bit          lru_mode;

  translation_t expected_translations [$];
  note_t        pending_notes [$];

  int mismatch_count;
  int items_sent;
  int tlb_hits, table_hits, faults, evictions, mode_writes;
  int quiet_cycles;
  int burst_left;
  int no_gap_items;
  bit hold_request;
  bit receiver_steady;
  logic [7:0] hot_pages [8];
  logic [7:0] warm_base;

  tlb_page_table_translator DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .replacement_mode (replacement_mode),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .virtual_address  (virtual_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic translation_t translate_address(input logic [VA_W-1:0] va);
    translation_t res;
    logic [7:0]   page;
    logic [6:0]   frame;
    logic         found;
    logic         hit;
    int           victim;
    int           slot;
    page  = va[15:8];
    frame = '0;
    found = 1'b0;
    hit   = 1'b0;
    for (int i = 0; i < TLB_SLOTS && !found; i++) begin
      if (tlb_valid[i] && slot_page[i] == page) begin
        frame = tlb_frame[i];
        found = 1'b1;
        hit   = 1'b1;
      end
    end
    for (int i = 0; i < FRAMES && !found; i++) begin
      if (frm_valid[i] && frm_page[i] == page) begin
        frame = i[6:0];
        found = 1'b1;
      end
    end
    if (found) begin
      frm_used[frame] = stamp_clock;
      if (hit) tlb_hits++;
      else table_hits++;
    end else begin
      victim = -1;
      for (int i = 0; i < FRAMES; i++) begin
        if (!frm_valid[i] && victim < 0) victim = i;
      end
      if (victim < 0) begin
        // strict compare keeps the lowest index on equal stamps
        victim = 0;
        for (int i = 1; i < FRAMES; i++) begin
          if ((lru_mode ? frm_used[i] : frm_load[i]) <
              (lru_mode ? frm_used[victim] : frm_load[victim])) victim = i;
        end
        for (int i = 0; i < TLB_SLOTS; i++) begin
          if (tlb_valid[i] && tlb_frame[i] == victim[6:0]) tlb_valid[i] = 1'b0;
        end
        evictions++;
      end
      frame            = victim[6:0];
      frm_valid[frame] = 1'b1;
      frm_page[frame]  = page;
      frm_load[frame]  = stamp_clock;
      frm_used[frame]  = stamp_clock;
      slot = -1;
      for (int i = 0; i < TLB_SLOTS; i++) begin
        if (!tlb_valid[i] && slot < 0) slot = i;
      end
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < TLB_SLOTS; i++) begin
          if (tlb_born[i] < tlb_born[slot]) slot = i;
        end
      end
      tlb_valid[slot] = 1'b1;
      slot_page[slot] = page;
      tlb_frame[slot] = frame;
      tlb_born[slot]  = stamp_clock;
      faults++;
    end
    stamp_clock = stamp_clock + 1;
    res.va    = va;
    res.pa    = {frame, va[7:0]};
    res.hit   = hit;
    res.fault = !found;
    return res;
  endfunction

  // most often a small hot set, then a window wider than the frame table, then anything
  function automatic logic [VA_W-1:0] pick_address();
    int         roll;
    logic [7:0] page;
    roll = $urandom_range(0, 99);
    if (roll < 5) hot_pages[$urandom_range(0, 7)] = 8'($urandom);
    if (roll < 45) page = hot_pages[$urandom_range(0, 7)];
    else if (roll < 80) page = warm_base + 8'($urandom_range(0, 139));
    else page = 8'($urandom);
    return {page, 8'($urandom)};
  endfunction

  always @(posedge clk) begin : scoreboard
    translation_t want;
    translation_t prediction;
    note_t        note;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_translations.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result: pa %h hit %b fault %b",
                     physical_address, tlb_hit, page_fault);
        end else begin
          want = expected_translations.pop_front();
          if (physical_address !== want.pa || tlb_hit !== want.hit ||
              page_fault !== want.fault) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("mismatch va %h: pa exp %h got %h, hit exp %b got %b, fault exp %b got %b",
                       want.va, want.pa, physical_address, want.hit, tlb_hit,
                       want.fault, page_fault);
          end
        end
      end
      if (in_valid && in_ready) begin
        prediction = translate_address(virtual_address);
        note = (pending_notes.size() != 0) ? pending_notes.pop_front() : '0;
        expected_translations.insert(expected_translations.size(),
                                     note.typed ? note.value : prediction);
      end
      if (cfg_valid && cfg_ready) lru_mode = replacement_mode;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!receiver_steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic offer_address(input logic [VA_W-1:0] va, input logic typed,
                               input translation_t typed_value);
    note_t note;
    note.typed      = typed;
    note.value      = typed_value;
    in_valid        <= 1'b1;
    virtual_address <= va;
    pending_notes.insert(pending_notes.size(), note);
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic pace_sender();
    int gap;
    gap = 0;
    if (no_gap_items > 0) begin
      no_gap_items--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap        = $urandom_range(1, 25);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (expected_translations.size() != 0);
  endtask

  task automatic set_replacement_mode(input logic mode);
    cfg_valid        <= 1'b1;
    replacement_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  task automatic run_random_phase(input logic mode, input bit long_hold, input bit steady,
                                  input int pause_at);
    wait_drained();
    set_replacement_mode(mode);
    receiver_steady = steady;
    hold_request    = long_hold;
    no_gap_items    = long_hold ? 16 : 0;
    warm_base       = 8'($urandom);
    foreach (hot_pages[i]) hot_pages[i] = 8'($urandom);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == pause_at) begin
        // let the block run dry before going on
        in_valid <= 1'b0;
        wait_drained();
      end
      offer_address(pick_address(), 1'b0, '0);
      if (n != PHASE_ITEMS - 1) pace_sender();
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    translation_t typed_value;
    int           failures;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      typed_value = '{DIRECTED[i].va, DIRECTED[i].pa, DIRECTED[i].hit, DIRECTED[i].fault};
      offer_address(DIRECTED[i].va, DIRECTED[i].typed, typed_value);
      if (i != $size(DIRECTED) - 1) pace_sender();
    end
    in_valid <= 1'b0;

    run_random_phase(1'b1, 1'b1, 1'b0, -1);
    run_random_phase(1'b0, 1'b0, 1'b0, PHASE_ITEMS / 2);
    run_random_phase(1'b1, 1'b0, 1'b1, -1);
    run_random_phase(1'b0, 1'b0, 1'b0, -1);

    wait_drained();
    repeat (200) @(posedge clk);
    failures = mismatch_count + expected_translations.size();
    $display("translated %0d addresses (%0d directed): %0d tlb hits, %0d frame table hits",
             items_sent, $size(DIRECTED), tlb_hits, table_hits);
    $display("%0d faults with %0d evictions over %0d fifo/lru mode writes, %0d mismatches",
             faults, evictions, mode_writes, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/tpt_pkg.sv
design/tpt_victim_track.sv
design/tpt_frame_store.sv
design/tpt_tlb_store.sv
design/tlb_page_table_translator.sv
tb/testbench.sv
